// File: rtl/core/fat_chain_allocator_core_macros.svh
// Assertion macros for the allocator core.
// ASSERT_NOW: consequent checked in the same cycle as the antecedent.
// ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef FAT_CHAIN_ALLOCATOR_CORE_MACROS_SVH
`define FAT_CHAIN_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTH
`define FCA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fca assertion failed");
`define FCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fca assertion failed");
`else
`define FCA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FCA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/fca_pkg.sv
package fca_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int CNT_W       = BLK_W + 1;
  localparam int ENTRY_W     = 11;

  localparam logic [ENTRY_W-1:0] ENTRY_FREE = '0;
  localparam logic [ENTRY_W-1:0] ENTRY_END  = '1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // register index (word address)
  localparam logic REG_FIRST_DATA_BLOCK = 1'b0;

  typedef enum logic [2:0] {
    ACT_CLEAR = 3'd0,
    ACT_READ  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_ALLOC = 3'd3,
    ACT_FREE  = 3'd4,
    ACT_NTH   = 3'd5,
    ACT_LEN   = 3'd6
  } act_t;

endpackage

// File: rtl/core/fat_chain_allocator_core.sv
// File allocation table core: one next-pointer entry per disk block, held in
// a 1024 x 11 synchronous RAM (one read and one write port, registered read
// data, same-cycle write forwarded to the read side).
// Input channel (in_*): one transfer carries one action in in_tuser and its
// operands in in_tdata. Output channel (out_*): exactly one result transfer
// per input transfer, in order.
// Config (cfg_*): APB register first_data_block at byte address 0.
// Steps from the accepting edge to raising out_tvalid, by action:
//   write / unknown action / nth with zero steps: straight to the result state
//   read: one RAM read; allocate: blocks scanned in turn (plus a link write when linking)
//   free chain, nth, chain length: entries read in turn (one RAM read a cycle)
//   clear: a sweep over all 1024 entries (one entry written a cycle)
// The RAM read-modify-write loop sets the rate: one item at a time; the next
// item can be taken in the cycle after the result is loaded.
// Reset: a clearing sweep writes all 1024 entries free; in_tready
// stays low during it. Config writes are taken at any time.
// Output stall: the finished result sits in an output register; the core
// accepts the next item meanwhile and holds its next result until the
// register frees up.
`include "fat_chain_allocator_core_macros.svh"

module fat_chain_allocator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // tdata: block[9:0], has_prev[10], write_value[21:11], step_count[31:22]
  input  logic [fca_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser: action[2:0]
  input  logic [2:0]                      in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: read_value[10:0], result_block[20:11], chain_length[31:21],
  //        ok[32], zero[39:33]
  output logic [fca_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [2:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import fca_pkg::*;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_WALK = 5'b00100,
    S_LINK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // ---------------- input fields ----------------
  logic [BLK_W-1:0]   in_block;
  logic               in_has_prev;
  logic [ENTRY_W-1:0] in_write_value;
  logic [BLK_W-1:0]   in_step_count;
  act_t               in_action;

  assign in_block       = in_tdata[BLK_W-1:0];
  assign in_has_prev    = in_tdata[10];
  assign in_write_value = in_tdata[21:11];
  assign in_step_count  = in_tdata[31:22];
  assign in_action      = act_t'(in_tuser);

  // ---------------- config register ----------------
  logic [BLK_W-1:0] fdb_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_FIRST_DATA_BLOCK);
  assign cfg_prdata = (cfg_paddr[2] == REG_FIRST_DATA_BLOCK) ?
                      {{(32-BLK_W){1'b0}}, fdb_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fdb_r <= BLK_W'(1);
    end else if (cfg_wr) begin
      fdb_r <= cfg_pwdata[BLK_W-1:0];
    end
  end

  // ---------------- table RAM ----------------
  logic [ENTRY_W-1:0] mem [0:NUM_BLOCKS-1];
  logic               mem_we;
  logic [BLK_W-1:0]   mem_wa;
  logic [ENTRY_W-1:0] mem_wd;
  logic [BLK_W-1:0]   mem_ra;
  logic [ENTRY_W-1:0] mem_q_r;
  logic               fwd_r;
  logic [ENTRY_W-1:0] fwd_data_r;
  logic [ENTRY_W-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  // read-during-write to one entry returns the new value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= mem_we && (mem_wa == mem_ra);
    end
    fwd_data_r <= mem_wd;
  end

  assign rd_q = fwd_r ? fwd_data_r : mem_q_r;

  // ---------------- control ----------------
  state_t             state_r, state_nxt;
  act_t               op_r, op_nxt;
  logic [BLK_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic               has_prev_r, has_prev_nxt;
  logic [BLK_W-1:0]   steps_r, steps_nxt;
  logic               clr_report_r, clr_report_nxt;
  logic [ENTRY_W-1:0] res_rd_r, res_rd_nxt;
  logic [BLK_W-1:0]   res_blk_r, res_blk_nxt;
  logic [CNT_W-1:0]   res_len_r, res_len_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic               in_fire;
  logic               q_stop;     // entry is end, free or negative
  logic [CNT_W-1:0]   cnt_inc;
  logic               out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign q_stop    = rd_q[ENTRY_W-1] || (rd_q == ENTRY_FREE);
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    blk_nxt        = blk_r;
    has_prev_nxt   = has_prev_r;
    steps_nxt      = steps_r;
    clr_report_nxt = clr_report_r;
    res_rd_nxt     = res_rd_r;
    res_blk_nxt    = res_blk_r;
    res_len_nxt    = res_len_r;
    res_ok_nxt     = res_ok_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = cur_r;
    mem_wd         = ENTRY_FREE;
    mem_ra         = cur_r;

    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = cur_r;
        mem_wd = ENTRY_FREE;
        if (cur_r == BLK_W'(NUM_BLOCKS - 1)) begin
          state_nxt      = clr_report_r ? S_DONE : S_IDLE;
          clr_report_nxt = 1'b0;
        end else begin
          cur_nxt = cur_r + BLK_W'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_action;
          blk_nxt      = in_block;
          has_prev_nxt = in_has_prev;
          steps_nxt    = in_step_count;
          cnt_nxt      = '0;
          cur_nxt      = in_block;
          mem_ra       = in_block;
          res_rd_nxt   = '0;
          res_blk_nxt  = '0;
          res_len_nxt  = '0;
          res_ok_nxt   = 1'b0;
          case (in_action) inside
            ACT_CLEAR: begin
              cur_nxt        = '0;
              clr_report_nxt = 1'b1;
              res_ok_nxt     = 1'b1;
              state_nxt      = S_CLR;
            end
            ACT_WRITE: begin
              mem_we     = 1'b1;
              mem_wa     = in_block;
              mem_wd     = in_write_value;
              res_ok_nxt = 1'b1;
              state_nxt  = S_DONE;
            end
            ACT_ALLOC: begin
              cur_nxt   = fdb_r;
              mem_ra    = fdb_r;
              state_nxt = S_WALK;
            end
            ACT_NTH: begin
              if (in_step_count == '0) begin
                res_blk_nxt = in_block;
                res_ok_nxt  = 1'b1;
                state_nxt   = S_DONE;
              end else begin
                state_nxt = S_WALK;
              end
            end
            ACT_READ, ACT_FREE, ACT_LEN: begin
              state_nxt = S_WALK;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // rd_q holds the entry at cur_r
      S_WALK: begin
        case (op_r)
          ACT_READ: begin
            res_rd_nxt = rd_q;
            res_ok_nxt = 1'b1;
            state_nxt  = S_DONE;
          end
          ACT_ALLOC: begin
            if (rd_q == ENTRY_FREE) begin
              mem_we      = 1'b1;
              mem_wa      = cur_r;
              mem_wd      = ENTRY_END;
              res_blk_nxt = cur_r;
              res_ok_nxt  = 1'b1;
              state_nxt   = has_prev_r ? S_LINK : S_DONE;
            end else if (cur_r == BLK_W'(NUM_BLOCKS - 1)) begin
              state_nxt = S_DONE;    // disk full
            end else begin
              cur_nxt = cur_r + BLK_W'(1);
              mem_ra  = cur_r + BLK_W'(1);
            end
          end
          ACT_FREE: begin
            mem_we  = 1'b1;
            mem_wa  = cur_r;
            mem_wd  = ENTRY_FREE;
            cnt_nxt = cnt_inc;
            if (q_stop || (cnt_inc == CNT_W'(NUM_BLOCKS))) begin
              res_ok_nxt = 1'b1;
              state_nxt  = S_DONE;
            end else begin
              cur_nxt = rd_q[BLK_W-1:0];
              mem_ra  = rd_q[BLK_W-1:0];
            end
          end
          ACT_NTH: begin
            if (q_stop) begin
              state_nxt = S_DONE;    // chain ended early
            end else begin
              cur_nxt = rd_q[BLK_W-1:0];
              cnt_nxt = cnt_inc;
              if (cnt_inc == {1'b0, steps_r}) begin
                res_blk_nxt = rd_q[BLK_W-1:0];
                res_ok_nxt  = 1'b1;
                state_nxt   = S_DONE;
              end else begin
                mem_ra = rd_q[BLK_W-1:0];
              end
            end
          end
          ACT_LEN: begin
            cnt_nxt = cnt_inc;
            if (q_stop || (cnt_inc == CNT_W'(NUM_BLOCKS))) begin
              res_len_nxt = cnt_inc;
              res_ok_nxt  = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              cur_nxt = rd_q[BLK_W-1:0];
              mem_ra  = rd_q[BLK_W-1:0];
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_LINK: begin
        // previous block points at the new one (overrides END on self-link)
        mem_we    = 1'b1;
        mem_wa    = blk_r;
        mem_wd    = {1'b0, cur_r};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_DATA_W - ENTRY_W - BLK_W - CNT_W - 1){1'b0}},
                           res_ok_r, res_len_r, res_blk_r, res_rd_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cur_r        <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
      op_r         <= ACT_CLEAR;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      cnt_r        <= cnt_nxt;
    end
    blk_r      <= blk_nxt;
    has_prev_r <= has_prev_nxt;
    steps_r    <= steps_nxt;
    res_rd_r   <= res_rd_nxt;
    res_blk_r  <= res_blk_nxt;
    res_len_r  <= res_len_nxt;
    res_ok_r   <= res_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  // linking only follows a successful allocation
  `FCA_ASSERT_NOW(a_link_after_alloc, clk, rst_n,
    state_r == S_LINK, res_ok_r && (op_r == ACT_ALLOC))
  // counting walks never run past the step cap
  `FCA_ASSERT_NOW(a_walk_capped, clk, rst_n,
    (state_r == S_WALK) && ((op_r == ACT_FREE) || (op_r == ACT_LEN)),
    cnt_r < CNT_W'(NUM_BLOCKS))
  // a finished result waits while the output register is still occupied
  `FCA_ASSERT_NEXT(a_done_holds, clk, rst_n,
    (state_r == S_DONE) && out_valid_r && !out_tready,
    (state_r == S_DONE) && out_valid_r)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // two copies of the table model: one runs ahead while stimulus is built,
  // the other follows the transfers the core actually takes
  localparam int PLAN_COPY = 0;
  localparam int DUT_COPY  = 1;

  typedef struct packed {
    act_t                     action;
    logic [BLK_W-1:0]         blk;
    logic                     has_prev;
    logic [ENTRY_W-1:0]       wval;
    logic [BLK_W-1:0]         steps;
  } fat_req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] rd;
    logic [BLK_W-1:0]   blk;
    logic [CNT_W-1:0]   len;
    logic               ok;
  } fat_rsp_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [2:0]             in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [2:0]             cfg_paddr = '0;
  logic [31:0]            cfg_pwdata = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  // table model state, one per copy
  logic [ENTRY_W-1:0] fat_mem [2][NUM_BLOCKS];
  logic [BLK_W-1:0]   first_blk [2];

  fat_req_t    req_pending [$];   // built, not yet presented to the core
  fat_rsp_t    rsp_expected [$];  // predicted results awaiting their transfer
  fat_req_t    drv_req;
  int          send_gap = 0;
  int          stall_gap = 0;
  bit          idle_on = 1'b1;
  int          err_count = 0;
  int unsigned cycle_cnt = 0;

  // files the stimulus knows about (head and last block of each chain)
  logic [BLK_W-1:0] file_head [$];
  logic [BLK_W-1:0] file_tail [$];

  fat_chain_allocator_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Table model. Walks are capped at NUM_BLOCKS steps; an entry that is
  // zero or negative ends every walk.
  function automatic fat_rsp_t fat_exec(input int cp, input fat_req_t r);
    fat_rsp_t                  rsp;
    logic [BLK_W-1:0]          cur;
    logic signed [ENTRY_W-1:0] nxt;
    int                        i;
    int                        n;
    rsp = '0;
    cur = r.blk;
    case (r.action)
      ACT_CLEAR: begin
        for (i = 0; i < NUM_BLOCKS; i++) fat_mem[cp][i] = ENTRY_FREE;
        rsp.ok = 1'b1;
      end
      ACT_READ: begin
        rsp.rd = fat_mem[cp][r.blk];
        rsp.ok = 1'b1;
      end
      ACT_WRITE: begin
        fat_mem[cp][r.blk] = r.wval;
        rsp.ok = 1'b1;
      end
      ACT_ALLOC: begin
        // first free entry from first_data_block up; with a link back to
        // the new block itself, the link write wins over the end mark
        for (i = first_blk[cp]; i < NUM_BLOCKS; i++) begin
          if (fat_mem[cp][i] == ENTRY_FREE) begin
            fat_mem[cp][i] = ENTRY_END;
            if (r.has_prev) fat_mem[cp][r.blk] = ENTRY_W'(i);
            rsp.blk = BLK_W'(i);
            rsp.ok  = 1'b1;
            break;
          end
        end
      end
      ACT_FREE: begin
        for (i = 0; i < NUM_BLOCKS; i++) begin
          nxt = fat_mem[cp][cur];
          fat_mem[cp][cur] = ENTRY_FREE;
          if (nxt <= 0) break;
          cur = nxt[BLK_W-1:0];
        end
        rsp.ok = 1'b1;
      end
      ACT_NTH: begin
        rsp.ok = 1'b1;
        for (i = 0; i < int'(r.steps); i++) begin
          nxt = fat_mem[cp][cur];
          if (nxt <= 0) begin
            rsp.ok = 1'b0;
            break;
          end
          cur = nxt[BLK_W-1:0];
        end
        rsp.blk = rsp.ok ? cur : '0;
      end
      ACT_LEN: begin
        n = 0;
        while (n < NUM_BLOCKS) begin
          n++;
          nxt = fat_mem[cp][cur];
          if (nxt <= 0) break;
          cur = nxt[BLK_W-1:0];
        end
        rsp.len = CNT_W'(n);
        rsp.ok  = 1'b1;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Runs the item on the look-ahead copy and queues it for the driver.
  task automatic queue_req(input fat_req_t r, output fat_rsp_t rsp);
    rsp = fat_exec(PLAN_COPY, r);
    req_pending.push_back(r);
  endtask

  task automatic put(input act_t act, input int blk, input bit hp, input int wv,
                     input int steps);
    fat_req_t r;
    fat_rsp_t rsp;
    r.action   = act;
    r.blk      = BLK_W'(blk);
    r.has_prev = hp;
    r.wval     = ENTRY_W'(wv);
    r.steps    = BLK_W'(steps);
    queue_req(r, rsp);
  endtask

  // Mostly well-formed file traffic: create, grow, walk and release
  // chains; now and then raw writes, reads and other actions anywhere, rarely a clear.
  task automatic add_random_req();
    fat_req_t r;
    fat_rsp_t rsp;
    int       sel;
    int       k;
    r.action   = act_t'($urandom_range(0, 6));
    r.blk      = BLK_W'($urandom);
    r.has_prev = 1'($urandom);
    r.wval     = ENTRY_W'($urandom_range(0, 1024) - 1);
    r.steps    = BLK_W'($urandom);
    sel = $urandom_range(0, 99);
    k   = (file_head.size() > 0) ? $urandom_range(0, file_head.size() - 1) : 0;
    if (sel == 99) begin
      r.action = ACT_CLEAR;
      file_head.delete();
      file_tail.delete();
    end else if (sel < 6) begin
      if (r.action == ACT_CLEAR) r.action = ACT_READ;
    end else if (file_head.size() == 0 || (sel < 30 && file_head.size() < 24)) begin
      r.action   = ACT_ALLOC;
      r.has_prev = 1'b0;
    end else if (sel < 55 && file_head.size() < 24) begin
      r.action   = ACT_ALLOC;
      r.has_prev = 1'b1;
      r.blk      = file_tail[k];
    end else if (sel < 65) begin
      r.action = ACT_LEN;
      r.blk    = file_head[k];
    end else if (sel < 75) begin
      r.action = ACT_NTH;
      r.blk    = file_head[k];
      if ($urandom_range(0, 19) != 0) r.steps = BLK_W'($urandom_range(0, 8));
    end else if (sel < 87) begin
      r.action = ACT_FREE;
      r.blk    = file_head[k];
    end else if (sel < 94) begin
      r.action = ACT_READ;
      if (sel < 90) r.blk = file_tail[k];
    end else begin
      r.action = ACT_WRITE;
    end
    queue_req(r, rsp);
    // keep the file list in step with what the look-ahead copy did;
    // raw traffic on random blocks is not tracked
    if (r.action == ACT_ALLOC && rsp.ok && sel >= 6) begin
      if (r.has_prev) begin
        file_tail[k] = rsp.blk;
      end else begin
        file_head.push_back(rsp.blk);
        file_tail.push_back(rsp.blk);
      end
    end else if (r.action == ACT_FREE && sel >= 75 && sel < 87) begin
      file_head.delete(k);
      file_tail.delete(k);
    end
  endtask

  // Waits until the core has taken every item and returned every result.
  task automatic settle();
    do @(negedge clk);
    while (req_pending.size() != 0 || in_tvalid || rsp_expected.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the
  // value on the edge that ends the access cycle
  task automatic cfg_write(input logic [BLK_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_FIRST_DATA_BLOCK, 2'b00};
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    first_blk[PLAN_COPY] = val;
    first_blk[DUT_COPY]  = val;
  endtask

  task automatic random_phase(input logic [BLK_W-1:0] fdb, input int n_items,
                              input bit idle);
    settle();
    cfg_write(fdb);
    idle_on = idle;
    repeat (n_items) add_random_req();
    settle();
  endtask

  // Main sequence
  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      fat_mem[PLAN_COPY][i] = ENTRY_FREE;
      fat_mem[DUT_COPY][i]  = ENTRY_FREE;
    end
    first_blk[PLAN_COPY] = 1;
    first_blk[DUT_COPY]  = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset value of first_data_block
    put(ACT_READ,  0,    0, 0,    0);
    put(ACT_WRITE, 1023, 0, -1,   0);
    put(ACT_READ,  1023, 0, 0,    0);
    put(ACT_ALLOC, 0,    0, 0,    0);   // gets 1
    put(ACT_ALLOC, 1,    1, 0,    0);   // 1 -> 2
    put(ACT_ALLOC, 2,    1, 0,    0);   // 2 -> 3
    put(ACT_LEN,   1,    0, 0,    0);
    put(ACT_NTH,   1,    0, 0,    2);
    put(ACT_NTH,   1,    0, 0,    0);
    put(ACT_NTH,   1,    0, 0,    3);   // runs off the end
    put(ACT_NTH,   600,  0, 0,    1);   // starts on a free entry
    put(ACT_ALLOC, 4,    1, 0,    0);   // previous block is the new one
    put(ACT_LEN,   4,    0, 0,    0);   // self loop, hits the walk cap
    put(ACT_NTH,   4,    0, 0,    1023);
    put(ACT_FREE,  4,    0, 0,    0);
    put(ACT_FREE,  1,    0, 0,    0);
    put(ACT_LEN,   1,    0, 0,    0);
    put(ACT_WRITE, 0,    0, 1023, 0);
    put(ACT_LEN,   0,    0, 0,    0);
    put(ACT_FREE,  700,  0, 0,    0);
    put(ACT_WRITE, 1023, 0, 0,    0);
    put(ACT_READ,  1023, 0, 0,    0);
    put(ACT_CLEAR, 0,    0, 0,    0);
    put(ACT_READ,  0,    0, 0,    0);
    // sender holds off here until everything has come back
    settle();

    // only the top block is allocatable: disk full after one allocation
    cfg_write(BLK_W'(1023));
    put(ACT_ALLOC, 0,    0, 0,    0);
    put(ACT_ALLOC, 5,    1, 0,    0);
    put(ACT_READ,  5,    0, 0,    0);
    put(ACT_FREE,  1023, 0, 0,    0);
    put(ACT_ALLOC, 0,    1, 0,    0);
    put(ACT_LEN,   0,    0, 0,    0);

    random_phase(BLK_W'(1), 200, 1'b1);
    random_phase(BLK_W'($urandom_range(2, 64)), 150, 1'b1);
    random_phase(BLK_W'(1023), 20, 1'b1);
    random_phase(BLK_W'($urandom_range(500, 1000)), 90, 1'b1);
    // last stretch runs with no idling on either side
    random_phase(BLK_W'(1), 100, 1'b0);

    repeat (40) @(negedge clk);
    if (err_count == 0 && rsp_expected.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Input driver: presents queued items, with random hold-off bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      // transfer taken: predict its result from the item just presented
      if (in_tvalid && in_tready) rsp_expected.push_back(fat_exec(DUT_COPY, drv_req));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 15);
          in_tvalid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          drv_req = req_pending.pop_front();
          in_tdata  <= {drv_req.steps, drv_req.wval, drv_req.has_prev, drv_req.blk};
          in_tuser  <= drv_req.action;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random stall bursts on out_tready, field-wise compare
  always @(posedge clk) begin
    fat_rsp_t want;
    fat_rsp_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.rd  = out_tdata[10:0];
        got.blk = out_tdata[20:11];
        got.len = out_tdata[31:21];
        got.ok  = out_tdata[32];
        if (rsp_expected.size() == 0) begin
          $error("result transfer with no result expected: %h", out_tdata);
          err_count++;
        end else begin
          want = rsp_expected.pop_front();
          if (got.rd !== want.rd) begin
            $error("read_value: expected %0d, got %0d", $signed(want.rd), $signed(got.rd));
            err_count++;
          end
          if (got.blk !== want.blk) begin
            $error("result_block: expected %0d, got %0d", want.blk, got.blk);
            err_count++;
          end
          if (got.len !== want.len) begin
            $error("chain_length: expected %0d, got %0d", want.len, got.len);
            err_count++;
          end
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            err_count++;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_gap = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule
